/* sv/gsp_pkg.sv */
// Shared types and constants for the simple-packing unpacker.
package gsp_pkg;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 48;
  localparam int unsigned FracBits = 24;

  // Register indexes on the configuration port
  typedef enum logic [CfgIdxW-1:0] {
    REG_BITS_PER_VALUE = 3'd0,
    REG_POINT_COUNT    = 3'd1,
    REG_REF_VALUE      = 3'd2,
    REG_BIN_SCALE      = 3'd3,
    REG_DECIMAL_GAIN   = 3'd4
  } cfg_reg_t;

  localparam logic [5:0]  BPV_RESET   = 6'd8;
  localparam logic [39:0] GAIN_RESET  = 40'd16777216;
  localparam logic [5:0]  WIDTH_MAX   = 6'd32;

  localparam logic signed [6:0] EXP_MIN  = -7'sd32;
  localparam logic signed [6:0] EXP_MAX  = 7'sd32;
  localparam logic signed [6:0] EXP_BIAS = 7'sd24;

  localparam logic [63:0] VALUE_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VALUE_MIN = 64'h8000_0000_0000_0000;

  typedef struct packed {
    logic [5:0]         bits_per_value;
    logic [31:0]        point_count;
    logic signed [47:0] ref_value;
    logic signed [6:0]  bin_scale;
    logic [39:0]        decimal_gain;
  } cfg_t;

  // One unpacked field on its way to the decoder
  typedef struct packed {
    logic [31:0] raw;
    logic [31:0] index;
    logic        last_of_byte;
    logic        last_point;
  } field_t;

endpackage

/* sv/gsp_unpack.sv */
// Bit extractor: cuts incoming bytes into fields, at most one field a cycle.
module gsp_unpack import gsp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  data_byte,
  input  logic        section_end,
  output logic        fld_valid,
  input  logic        fld_ready,
  output field_t      fld
);

  // Byte register: remaining bits sit at the top of byte_bits
  logic        a_valid;
  logic [7:0]  byte_bits;
  logic [3:0]  rem;
  logic        end_flag;

  // Field collection state
  logic [31:0] acc;
  logic [5:0]  held;
  logic [31:0] pd;

  logic [31:0] acc_next;
  logic [5:0]  held_next;
  logic [31:0] pd_next;
  logic [7:0]  byte_bits_next;
  logic [3:0]  rem_next;

  logic [5:0]  width;
  logic        stopped;
  logic [5:0]  need;
  logic [3:0]  take;
  logic [31:0] acc_sh;
  logic [5:0]  held_sh;
  logic        complete;
  logic [31:0] mask;
  logic [3:0]  r2;
  logic        last_pt;
  logic [7:0]  rest;
  logic        emit;
  logic        done;
  logic        adv;

  // Clamp the field width to 32
  assign width = (cfg.bits_per_value > WIDTH_MAX) ? WIDTH_MAX : cfg.bits_per_value;

  // Take bits up to the next field boundary or the end of the byte
  always_comb begin
    stopped  = (pd >= cfg.point_count);
    need     = (held >= width) ? 6'd1 : (width - held);
    take     = (need < {2'b00, rem}) ? need[3:0] : rem;
    acc_sh   = (acc << take) | {24'd0, byte_bits >> (4'd8 - take)};
    held_sh  = held + {2'b00, take};
    complete = (held_sh >= width);
    mask     = 32'hFFFF_FFFF >> (WIDTH_MAX - width);
    r2       = rem - take;
    last_pt  = (cfg.point_count != 32'd0) && (pd == cfg.point_count - 32'd1);
    rest     = byte_bits << take;

    emit           = 1'b0;
    done           = 1'b1;
    acc_next       = acc;
    held_next      = held;
    pd_next        = pd;
    byte_bits_next = byte_bits;
    rem_next       = rem;

    if (width == 6'd0 || stopped) begin
      // drop the whole byte
    end else if (!complete) begin
      acc_next  = acc_sh;
      held_next = held_sh;
    end else begin
      emit    = 1'b1;
      pd_next = pd + 32'd1;
      if (r2 == 4'd0 || last_pt) begin
        // byte used up, or point count reached: drop what is left
        acc_next  = 32'd0;
        held_next = 6'd0;
      end else if ({2'b00, r2} < width) begin
        // leftover bits start the next field at once
        acc_next  = {24'd0, rest >> (4'd8 - r2)};
        held_next = {2'b00, r2};
      end else begin
        // another full field lies in this byte: continue next cycle
        acc_next       = 32'd0;
        held_next      = 6'd0;
        byte_bits_next = rest;
        rem_next       = r2;
        done           = 1'b0;
      end
    end
  end

  assign adv       = a_valid && (!emit || fld_ready);
  assign in_ready  = !a_valid || (adv && done);
  assign fld_valid = a_valid && emit;

  always_comb begin
    fld.raw          = acc_sh & mask;
    fld.index        = pd;
    fld.last_of_byte = done;
    fld.last_point   = last_pt;
  end

  // Advance collection state; clear it after a section-end word
  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      acc     <= 32'd0;
      held    <= 6'd0;
      pd      <= 32'd0;
    end else begin
      if (adv) begin
        if (done && end_flag) begin
          acc  <= 32'd0;
          held <= 6'd0;
          pd   <= 32'd0;
        end else begin
          acc  <= acc_next;
          held <= held_next;
          pd   <= pd_next;
        end
      end
      if (in_valid && in_ready) begin
        a_valid <= 1'b1;
      end else if (adv && done) begin
        a_valid <= 1'b0;
      end
    end
  end

  // Load a new word, or hold the remaining bits
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_bits <= data_byte;
      rem       <= 4'd8;
      end_flag  <= section_end;
    end else if (adv) begin
      byte_bits <= byte_bits_next;
      rem       <= rem_next;
    end
  end

`ifndef ASSERT_OFF
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    adv && done && end_flag |=> pd == 32'd0 && held == 6'd0)
    else $error("state not cleared after section end");

  a_emit_in_range: assert property (@(posedge clk) disable iff (rst)
    fld_valid |-> width != 6'd0 && pd < cfg.point_count)
    else $error("field emitted with zero width or past point count");

  a_held_bound: assert property (@(posedge clk) disable iff (rst)
    held < WIDTH_MAX)
    else $error("partial field holds a full width of bits");
`endif

endmodule

/* sv/gsp_decode.sv */
// Decode pipeline: scale, offset, gain, round and saturate each field.
module gsp_decode import gsp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  cfg_t               cfg,
  input  logic               fld_valid,
  output logic               fld_ready,
  input  field_t             fld,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [63:0] value,
  output logic [31:0]        raw_field,
  output logic [31:0]        point_index,
  output logic               saturated,
  output logic               last_of_byte,
  output logic               last_point
);

  logic rdy1, rdy2, rdy3, rdy4, rdy5;

  // Stage 1: field register
  logic   v1;
  field_t f1;

  // Stage 2: magnitude after shift and offset
  logic        v2;
  field_t      f2;
  logic [87:0] mag2;
  logic        neg2;
  logic        big2;

  // Stage 3: partial products
  logic        v3;
  field_t      f3;
  logic        neg3;
  logic        big3;
  logic [63:0] pp00;
  logic [63:0] pp10;
  logic [55:0] pp20;
  logic [39:0] pp01;
  logic [39:0] pp11;
  logic [31:0] pp21;

  // Stage 4: rounded product
  logic         v4;
  field_t       f4;
  logic         neg4;
  logic         big4;
  logic [127:0] prod4;

  logic signed [6:0] bs;
  logic signed [6:0] exp_c;
  logic signed [6:0] sh;
  logic [6:0]        nsh;
  logic [87:0]       a_val;
  logic [47:0]       ref_u;
  logic              rneg;
  logic [47:0]       rmag;
  logic [88:0]       sum_pos;
  logic [88:0]       diff;
  logic [88:0]       m;
  logic              neg1;

  logic [63:0]  pp00_c;
  logic [63:0]  pp10_c;
  logic [55:0]  pp20_c;
  logic [39:0]  pp01_c;
  logic [39:0]  pp11_c;
  logic [31:0]  pp21_c;
  logic [127:0] prod_c;

  logic [63:0] q;
  logic        over;
  logic [63:0] val_c;
  logic        sat_c;

  assign rdy5      = !out_valid || out_ready;
  assign rdy4      = !v4 || rdy5;
  assign rdy3      = !v3 || rdy4;
  assign rdy2      = !v2 || rdy3;
  assign rdy1      = !v1 || rdy2;
  assign fld_ready = rdy1;

  // Shift by the clamped binary exponent and add the reference value
  always_comb begin
    bs = cfg.bin_scale;
    if (bs < EXP_MIN) begin
      exp_c = EXP_MIN;
    end else if (bs > EXP_MAX) begin
      exp_c = EXP_MAX;
    end else begin
      exp_c = bs;
    end
    sh  = exp_c + EXP_BIAS;
    nsh = 7'd0 - sh;
    if (sh < 7'sd0) begin
      a_val = {56'd0, f1.raw >> nsh[3:0]};
    end else begin
      a_val = {56'd0, f1.raw} << sh[5:0];
    end
    ref_u   = cfg.ref_value;
    rneg    = ref_u[47];
    rmag    = rneg ? (48'd0 - ref_u) : ref_u;
    sum_pos = {1'b0, a_val} + {41'd0, rmag};
    diff    = {1'b0, a_val} - {41'd0, rmag};
    if (!rneg) begin
      m    = sum_pos;
      neg1 = 1'b0;
    end else if (!diff[88]) begin
      m    = diff;
      neg1 = 1'b0;
    end else begin
      m    = {41'd0, rmag - a_val[47:0]};
      neg1 = 1'b1;
    end
  end

  // Split the gain multiply into six partial products
  always_comb begin
    pp00_c = mag2[31:0]  * cfg.decimal_gain[31:0];
    pp10_c = mag2[63:32] * cfg.decimal_gain[31:0];
    pp20_c = mag2[87:64] * cfg.decimal_gain[31:0];
    pp01_c = mag2[31:0]  * cfg.decimal_gain[39:32];
    pp11_c = mag2[63:32] * cfg.decimal_gain[39:32];
    pp21_c = mag2[87:64] * cfg.decimal_gain[39:32];
  end

  // Sum the partial products with the rounding half
  assign prod_c = {64'd0, pp00} + {32'd0, pp10, 32'd0} + {8'd0, pp20, 64'd0}
                + {56'd0, pp01, 32'd0} + {24'd0, pp11, 64'd0} + {pp21, 96'd0}
                + (128'd1 << (FracBits - 1));

  // Drop fraction bits, apply sign, clip to 64 bits
  always_comb begin
    q    = prod4[87:24];
    over = big4 || (|prod4[127:88]);
    if (over) begin
      sat_c = 1'b1;
      val_c = neg4 ? VALUE_MIN : VALUE_MAX;
    end else if (neg4) begin
      if (q > VALUE_MIN) begin
        sat_c = 1'b1;
        val_c = VALUE_MIN;
      end else begin
        sat_c = 1'b0;
        val_c = 64'd0 - q;
      end
    end else if (q[63]) begin
      sat_c = 1'b1;
      val_c = VALUE_MAX;
    end else begin
      sat_c = 1'b0;
      val_c = q;
    end
  end

  // Advance valid bits where the next stage is free
  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      v4        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (rdy1) v1 <= fld_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
      if (rdy4) v4 <= v3;
      if (rdy5) out_valid <= v4;
    end
  end

  // Move payload along with its valid bit
  always_ff @(posedge clk) begin
    if (rdy1) begin
      f1 <= fld;
    end
    if (rdy2) begin
      f2   <= f1;
      mag2 <= m[87:0];
      neg2 <= neg1;
      big2 <= m[88];
    end
    if (rdy3) begin
      f3   <= f2;
      neg3 <= neg2;
      big3 <= big2 && (cfg.decimal_gain != 40'd0);
      pp00 <= pp00_c;
      pp10 <= pp10_c;
      pp20 <= pp20_c;
      pp01 <= pp01_c;
      pp11 <= pp11_c;
      pp21 <= pp21_c;
    end
    if (rdy4) begin
      f4    <= f3;
      neg4  <= neg3;
      big4  <= big3;
      prod4 <= prod_c;
    end
    if (rdy5) begin
      value        <= val_c;
      saturated    <= sat_c;
      raw_field    <= f4.raw;
      point_index  <= f4.index;
      last_of_byte <= f4.last_of_byte;
      last_point   <= f4.last_point;
    end
  end

`ifndef ASSERT_OFF
  a_sat_limit: assert property (@(posedge clk) disable iff (rst)
    out_valid && saturated |-> value == VALUE_MIN || value == VALUE_MAX)
    else $error("saturated result not at a 64-bit limit");

  a_last_point_ends_byte: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_point |-> last_of_byte)
    else $error("last point not marked as last of its byte");

  a_out_fill: assert property (@(posedge clk) disable iff (rst)
    v4 && rdy5 |=> out_valid)
    else $error("finished result lost before output register");
`endif

endmodule

/* sv/grib_simple_packing_unpacker.sv */
// Top level of the simple-packing unpacker: configuration registers and the two parts.
// Each field passes the decode registers: field, offset, partial products, product, output.
// Throughput: one byte a cycle while no stall holds the output and each byte completes at
// most one field; a byte with more fields holds the input until the extractor has cut them.
// Reset (synchronous, rst high): clears the bit accumulator, point counter and pipeline
// valids, and loads the registers with their defaults; there is no clearing pass.
module grib_simple_packing_unpacker import gsp_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_write,
  input  logic [CfgIdxW-1:0]  cfg_index,
  input  logic [CfgDataW-1:0] cfg_data,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [7:0]          data_byte,
  input  logic                section_end,
  output logic                out_valid,
  input  logic                out_ready,
  output logic signed [63:0]  value,
  output logic [31:0]         raw_field,
  output logic [31:0]         point_index,
  output logic                saturated,
  output logic                last_of_byte,
  output logic                last_point
);

  cfg_t   cfg;
  logic   fld_valid;
  logic   fld_ready;
  field_t fld;

  // Write the configuration registers; unknown indexes are ignored
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.bits_per_value <= BPV_RESET;
      cfg.point_count    <= 32'd0;
      cfg.ref_value      <= 48'sd0;
      cfg.bin_scale      <= 7'sd0;
      cfg.decimal_gain   <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_BITS_PER_VALUE: cfg.bits_per_value <= cfg_data[5:0];
        REG_POINT_COUNT:    cfg.point_count    <= cfg_data[31:0];
        REG_REF_VALUE:      cfg.ref_value      <= cfg_data[47:0];
        REG_BIN_SCALE:      cfg.bin_scale      <= cfg_data[6:0];
        REG_DECIMAL_GAIN:   cfg.decimal_gain   <= cfg_data[39:0];
        default: ;
      endcase
    end
  end

  gsp_unpack u_unpack (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .data_byte   (data_byte),
    .section_end (section_end),
    .fld_valid   (fld_valid),
    .fld_ready   (fld_ready),
    .fld         (fld)
  );

  gsp_decode u_decode (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .fld_valid    (fld_valid),
    .fld_ready    (fld_ready),
    .fld          (fld),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .raw_field    (raw_field),
    .point_index  (point_index),
    .saturated    (saturated),
    .last_of_byte (last_of_byte),
    .last_point   (last_point)
  );

endmodule

/* bench/tb_grib_simple_packing_unpacker.sv */
// Self-checking bench for the simple-packing unpacker: directed table, then random sections.
module tb_grib_simple_packing_unpacker import gsp_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int RandomWords = 250;
  localparam int CycleLimit  = 600000;
  localparam int SettleWait  = 12;

  typedef enum logic [1:0] {
    ROW_CFG,
    ROW_BYTE,
    ROW_CHECKED
  } row_kind_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_PERIODIC,
    READY_SPARSE
  } ready_mode_t;

  // One step of the directed script
  typedef struct {
    row_kind_t   kind;
    cfg_reg_t    reg_idx;
    logic [47:0] wdata;
    logic [7:0]  octet;
    logic        closes;
    logic [63:0] want_value;
    logic        want_sat;
  } row_t;

  // One decoded grid point as the block should emit it
  typedef struct {
    logic [63:0] value;
    logic [31:0] raw;
    logic [31:0] pt_index;
    logic        saturated;
    logic        last_of_byte;
    logic        last_point;
  } point_t;

  logic                       clk = 1'b0;
  logic                       rst = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CfgIdxW-1:0]         cfg_index = '0;
  logic [CfgDataW-1:0]        cfg_data = '0;
  logic                       in_valid = 1'b0;
  logic                       in_ready;
  logic [7:0]                 data_byte = '0;
  logic                       section_end = 1'b0;
  logic                       out_valid;
  logic                       out_ready = 1'b0;
  logic signed [63:0]         value;
  logic [31:0]                raw_field;
  logic [31:0]                point_index;
  logic                       saturated;
  logic                       last_of_byte;
  logic                       last_point;

  grib_simple_packing_unpacker u_top (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .data_byte    (data_byte),
    .section_end  (section_end),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .value        (value),
    .raw_field    (raw_field),
    .point_index  (point_index),
    .saturated    (saturated),
    .last_of_byte (last_of_byte),
    .last_point   (last_point)
  );

  // Shadow registers and unpacking state
  cfg_t        shadow_cfg;
  logic [31:0] acc_q;
  int          held_q;
  logic [31:0] done_q;

  point_t pending_points[$];
  row_t   script[$];

  int errors = 0;
  int cycles = 0;
  int burst_left = 0;
  int words_sent = 0;
  int live_words = 0;
  int sections_closed = 0;
  int reg_writes = 0;
  int points_checked = 0;
  int sat_seen = 0;

  initial begin
    forever #2 clk = ~clk;
  end

  // Give up on a hung run
  always @(posedge clk) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("tb_grib_simple_packing_unpacker: errors");
      $finish;
    end
  end

  // Decode one raw field: (raw * 2^E + R) * gain, rounded half away from zero, clipped
  function automatic logic [63:0] scale_field(input logic [31:0] raw, output logic sat);
    int           e;
    int           sh;
    logic [127:0] a;
    logic [127:0] rmag;
    logic [127:0] mag;
    logic [191:0] prod;
    logic [191:0] q;
    logic         neg;
    e = $signed(shadow_cfg.bin_scale);
    if (e < int'(EXP_MIN)) e = int'(EXP_MIN);
    if (e > int'(EXP_MAX)) e = int'(EXP_MAX);
    sh = e + int'(FracBits);
    a = {96'd0, raw};
    if (sh >= 0) a = a << sh;
    else a = a >> (-sh);
    neg = 1'b0;
    if (shadow_cfg.ref_value[47]) begin
      rmag = {80'd0, ~shadow_cfg.ref_value} + 128'd1;
      if (a >= rmag) begin
        mag = a - rmag;
      end else begin
        mag = rmag - a;
        neg = 1'b1;
      end
    end else begin
      mag = a + {80'd0, shadow_cfg.ref_value};
    end
    prod = {64'd0, mag} * {152'd0, shadow_cfg.decimal_gain};
    q = (prod + (192'd1 << (FracBits - 1))) >> FracBits;
    sat = 1'b0;
    if (neg) begin
      if (q > {128'd0, VALUE_MIN}) begin
        sat = 1'b1;
        return VALUE_MIN;
      end
      return ~q[63:0] + 64'd1;
    end
    if (q > {128'd0, VALUE_MAX}) begin
      sat = 1'b1;
      return VALUE_MAX;
    end
    return q[63:0];
  endfunction

  // Shift one data word into the accumulator MSB first and queue every field it completes
  function automatic void unpack_word(input logic [7:0] octet, input logic closes,
                                      output int bits_used);
    int          w;
    int          first;
    logic [31:0] mask;
    logic        s;
    point_t      p;
    w = (shadow_cfg.bits_per_value > WIDTH_MAX) ? int'(WIDTH_MAX)
                                                : int'(shadow_cfg.bits_per_value);
    bits_used = 0;
    first = pending_points.size();
    if (w != 0) begin
      mask = (w == int'(WIDTH_MAX)) ? 32'hFFFF_FFFF : (32'd1 << w) - 32'd1;
      for (int i = 7; i >= 0; i--) begin
        if (done_q >= shadow_cfg.point_count) break;
        acc_q = {acc_q[30:0], octet[i]};
        held_q++;
        bits_used++;
        if (held_q >= w) begin
          p.raw = acc_q & mask;
          p.value = scale_field(p.raw, s);
          p.saturated = s;
          p.pt_index = done_q;
          p.last_of_byte = 1'b0;
          p.last_point = (shadow_cfg.point_count != 0) &&
                         (done_q == shadow_cfg.point_count - 32'd1);
          pending_points.insert(pending_points.size(), p);
          acc_q = '0;
          held_q = 0;
          done_q = done_q + 32'd1;
        end
      end
    end
    if (pending_points.size() > first)
      pending_points[pending_points.size()-1].last_of_byte = 1'b1;
    if (closes) begin
      acc_q = '0;
      held_q = 0;
      done_q = '0;
    end
  endfunction

  function automatic void check_field(input string name, input logic [63:0] want,
                                      input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %h, got %h", name, want, got);
      errors++;
    end
  endfunction

  function automatic void cfg_row(input cfg_reg_t idx, input logic [47:0] d);
    row_t r;
    r = '{kind: ROW_CFG, reg_idx: idx, wdata: d, octet: '0, closes: 1'b0,
          want_value: '0, want_sat: 1'b0};
    script.insert(script.size(), r);
  endfunction

  function automatic void byte_row(input logic [7:0] octet, input logic closes);
    row_t r;
    r = '{kind: ROW_BYTE, reg_idx: REG_BITS_PER_VALUE, wdata: '0, octet: octet,
          closes: closes, want_value: '0, want_sat: 1'b0};
    script.insert(script.size(), r);
  endfunction

  function automatic void checked_row(input logic [7:0] octet, input logic closes,
                                      input logic [63:0] want, input logic sat);
    row_t r;
    r = '{kind: ROW_CHECKED, reg_idx: REG_BITS_PER_VALUE, wdata: '0, octet: octet,
          closes: closes, want_value: want, want_sat: sat};
    script.insert(script.size(), r);
  endfunction

  // Write one register; the shadow copy follows
  task automatic set_reg(input cfg_reg_t idx, input logic [47:0] d);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
    case (idx)
      REG_BITS_PER_VALUE: shadow_cfg.bits_per_value = d[5:0];
      REG_POINT_COUNT:    shadow_cfg.point_count    = d[31:0];
      REG_REF_VALUE:      shadow_cfg.ref_value      = d;
      REG_BIN_SCALE:      shadow_cfg.bin_scale      = d[6:0];
      REG_DECIMAL_GAIN:   shadow_cfg.decimal_gain   = d[39:0];
      default: ;
    endcase
  endtask

  // Drop valid and wait until every queued point has come out and the pipe has settled
  task automatic drain_block();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_points.size() != 0);
    repeat (SettleWait) @(posedge clk);
  endtask

  // Sender pacing: bursts of random length, gaps between, now and then a full drain
  task automatic pace_sender();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 12);
      in_valid <= 1'b0;
      if ($urandom_range(0, 11) == 0) begin
        do @(posedge clk); while (pending_points.size() != 0);
      end else begin
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end
    end
  endtask

  // Offer one data word and hold it until accepted
  task automatic send_word(input logic [7:0] octet, input logic closes, output int bits_used);
    in_valid    <= 1'b1;
    data_byte   <= octet;
    section_end <= closes;
    do @(posedge clk); while (in_ready !== 1'b1);
    unpack_word(octet, closes, bits_used);
    words_sent++;
    if (closes) sections_closed++;
  endtask

  // Pick a fresh setting; the point count is always rewritten, often to fit the section
  task automatic randomise_setup(input int n_words);
    logic [47:0] d;
    logic [15:0] r16;
    int          w;
    if ($urandom_range(0, 2) != 0) begin
      case ($urandom_range(0, 9))
        0:       d = 48'd0;
        1:       d = 48'($urandom_range(33, 63));
        2:       d = 48'd32;
        3:       d = 48'd1;
        default: d = 48'($urandom_range(1, 32));
      endcase
      set_reg(REG_BITS_PER_VALUE, d);
    end
    if ($urandom_range(0, 1) == 0) begin
      r16 = 16'($urandom);
      case ($urandom_range(0, 6))
        0:       d = 48'h7FFF_FFFF_FFFF;
        1:       d = 48'h8000_0000_0000;
        2:       d = 48'd0;
        3, 4:    d = {{32{r16[15]}}, r16};
        default: d = {16'($urandom), 32'($urandom)};
      endcase
      set_reg(REG_REF_VALUE, d);
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 7))
        0:       d = 48'h20;
        1:       d = 48'h60;
        2:       d = 48'd0;
        3:       d = 48'h40;
        4:       d = 48'h3F;
        default: d = 48'($urandom_range(0, 127));
      endcase
      set_reg(REG_BIN_SCALE, d);
    end
    if ($urandom_range(0, 1) == 0) begin
      case ($urandom_range(0, 6))
        0:       d = 48'd0;
        1:       d = 48'hFF_FFFF_FFFF;
        2:       d = {8'd0, GAIN_RESET};
        3, 4:    d = 48'($urandom_range(0, 1 << 25));
        default: d = {8'd0, 8'($urandom), 32'($urandom)};
      endcase
      set_reg(REG_DECIMAL_GAIN, d);
    end
    w = (shadow_cfg.bits_per_value > WIDTH_MAX) ? int'(WIDTH_MAX)
                                                : int'(shadow_cfg.bits_per_value);
    case ($urandom_range(0, 9))
      0:       d = 48'd0;
      1:       d = 48'hFFFF_FFFF;
      2:       d = 48'($urandom);
      3, 4:    d = 48'($urandom_range(1, 48));
      default: d = (w == 0) ? 48'd5 : 48'((n_words * 8 / w > 0) ? n_words * 8 / w : 1);
    endcase
    set_reg(REG_POINT_COUNT, d);
  endtask

  // Result side: check each accepted point, then choose the next ready level
  ready_mode_t ready_mode = READY_ALWAYS;
  int          ready_left = 0;
  int          ready_tick = 0;
  int          ready_period = 2;

  always @(posedge clk) begin
    point_t want;
    if (!rst && out_valid === 1'b1 && out_ready) begin
      if (pending_points.size() == 0) begin
        $error("result with nothing expected: point_index %0d raw_field %h",
               point_index, raw_field);
        errors++;
      end else begin
        want = pending_points.pop_front();
        check_field("value", want.value, value);
        check_field("raw_field", {32'd0, want.raw}, {32'd0, raw_field});
        check_field("point_index", {32'd0, want.pt_index}, {32'd0, point_index});
        check_field("saturated", {63'd0, want.saturated}, {63'd0, saturated});
        check_field("last_of_byte", {63'd0, want.last_of_byte}, {63'd0, last_of_byte});
        check_field("last_point", {63'd0, want.last_point}, {63'd0, last_point});
        points_checked++;
        if (want.saturated) sat_seen++;
      end
    end
    if (ready_left == 0) begin
      ready_mode   = ready_mode_t'($urandom_range(0, 3));
      ready_left   = $urandom_range(16, 160);
      ready_period = $urandom_range(2, 5);
    end else begin
      ready_left--;
    end
    ready_tick++;
    case (ready_mode)
      READY_ALWAYS:   out_ready <= 1'b1;
      READY_COIN:     out_ready <= 1'($urandom_range(0, 1));
      READY_PERIODIC: out_ready <= (ready_tick % ready_period) != 0;
      default:        out_ready <= ($urandom_range(0, 9) == 0);
    endcase
  end

  initial begin
    int   used;
    int   n_words;
    logic keep_open;
    logic closes;

    shadow_cfg.bits_per_value = BPV_RESET;
    shadow_cfg.point_count    = '0;
    shadow_cfg.ref_value      = '0;
    shadow_cfg.bin_scale      = '0;
    shadow_cfg.decimal_gain   = GAIN_RESET;
    acc_q  = '0;
    held_q = 0;
    done_q = '0;

    // Reset setting has a zero point count: nothing comes out
    byte_row(8'hFF, 1'b0);
    byte_row(8'h00, 1'b1);
    // Byte-wide fields at unit gain: the field itself in 24-bit fixed point
    cfg_row(REG_POINT_COUNT, 48'd4);
    checked_row(8'h00, 1'b0, 64'h0, 1'b0);
    checked_row(8'hFF, 1'b0, 64'h0000_0000_FF00_0000, 1'b0);
    // Nibble fields reach the point count; the rest is ignored until section end
    cfg_row(REG_BITS_PER_VALUE, 48'd4);
    byte_row(8'hA5, 1'b0);
    byte_row(8'h3C, 1'b0);
    byte_row(8'h00, 1'b1);
    // One-bit fields: eight points from each word
    cfg_row(REG_BITS_PER_VALUE, 48'd1);
    cfg_row(REG_POINT_COUNT, 48'd16);
    byte_row(8'h81, 1'b0);
    byte_row(8'h7E, 1'b1);
    // Widest field, largest exponent, reference and gain: clips high
    cfg_row(REG_BITS_PER_VALUE, 48'd32);
    cfg_row(REG_POINT_COUNT, 48'd2);
    cfg_row(REG_BIN_SCALE, 48'h20);
    cfg_row(REG_REF_VALUE, 48'h7FFF_FFFF_FFFF);
    cfg_row(REG_DECIMAL_GAIN, 48'hFF_FFFF_FFFF);
    byte_row(8'hFF, 1'b0);
    byte_row(8'hFF, 1'b0);
    byte_row(8'hFF, 1'b0);
    checked_row(8'hFF, 1'b0, VALUE_MAX, 1'b1);
    // Most negative reference with a zero field, smallest exponent
    cfg_row(REG_REF_VALUE, 48'h8000_0000_0000);
    cfg_row(REG_BIN_SCALE, 48'h60);
    cfg_row(REG_DECIMAL_GAIN, {8'd0, GAIN_RESET});
    byte_row(8'h00, 1'b0);
    byte_row(8'h00, 1'b0);
    byte_row(8'h00, 1'b0);
    checked_row(8'h00, 1'b1, 64'hFFFF_8000_0000_0000, 1'b0);
    // Exact halves round away from zero on both signs
    cfg_row(REG_BITS_PER_VALUE, 48'd8);
    cfg_row(REG_REF_VALUE, 48'd1);
    cfg_row(REG_DECIMAL_GAIN, 48'h80_0000);
    checked_row(8'h00, 1'b0, 64'd1, 1'b0);
    cfg_row(REG_REF_VALUE, 48'hFFFF_FFFF_FFFF);
    checked_row(8'h00, 1'b1, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    // Zero width swallows the word
    cfg_row(REG_BITS_PER_VALUE, 48'd0);
    byte_row(8'h55, 1'b0);
    // Width above 32 acts as 32, exponent below range acts as the minimum
    cfg_row(REG_BITS_PER_VALUE, 48'd63);
    cfg_row(REG_BIN_SCALE, 48'h40);
    cfg_row(REG_REF_VALUE, 48'd0);
    cfg_row(REG_DECIMAL_GAIN, {8'd0, GAIN_RESET});
    cfg_row(REG_POINT_COUNT, 48'd1);
    byte_row(8'h12, 1'b0);
    byte_row(8'h34, 1'b0);
    byte_row(8'h56, 1'b0);
    checked_row(8'h78, 1'b1, 64'h0000_0000_0012_3456, 1'b0);

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Walk the directed script
    foreach (script[k]) begin
      if (script[k].kind == ROW_CFG) begin
        drain_block();
        set_reg(script[k].reg_idx, script[k].wdata);
      end else begin
        pace_sender();
        send_word(script[k].octet, script[k].closes, used);
        if (script[k].kind == ROW_CHECKED) begin
          pending_points[pending_points.size()-1].value     = script[k].want_value;
          pending_points[pending_points.size()-1].saturated = script[k].want_sat;
        end
      end
    end

    // Random sections until the word budget is spent, sometimes left open across setups
    while (words_sent < RandomWords) begin
      n_words = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 16);
      keep_open = ($urandom_range(0, 4) == 0);
      drain_block();
      randomise_setup(n_words);
      for (int i = 0; i < n_words; i++) begin
        closes = (!keep_open && i == n_words - 1) || ($urandom_range(0, 49) == 0);
        pace_sender();
        send_word(8'($urandom), closes, used);
        if (used > 0) live_words++;
      end
    end

    drain_block();
    $display("Sent %0d data words (%0d random ones carrying field bits) in %0d closed sections",
             words_sent, live_words, sections_closed);
    $display("with %0d register writes; checked %0d decoded points, %0d of them clipped.",
             reg_writes, points_checked, sat_seen);
    if (errors == 0) begin
      $display("tb_grib_simple_packing_unpacker: clean");
    end else begin
      $display("tb_grib_simple_packing_unpacker: errors");
    end
    $finish;
  end

endmodule

/* grib_simple_packing_unpacker.f */
sv/gsp_pkg.sv
sv/gsp_unpack.sv
sv/gsp_decode.sv
sv/grib_simple_packing_unpacker.sv
bench/tb_grib_simple_packing_unpacker.sv
